[rtl/ring_mesh_triangle_indexer_macros.svh]
// ----------------------------------------------------------------------------
// Ring mesh triangle indexer: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RING_MESH_TRIANGLE_INDEXER_MACROS_SVH
`define RING_MESH_TRIANGLE_INDEXER_MACROS_SVH

// Same-cycle implication.
`define RMTI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RMTI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rmti_pkg.sv]
// ----------------------------------------------------------------------------
// Ring mesh triangle indexer package
// Widths, codes and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rmti_pkg;

    localparam int TRI_W      = 17;
    localparam int VERT_W     = 17;
    localparam int HALF_W     = 8;
    localparam int RINGS_W    = 9;
    localparam int P_W        = HALF_W + 1;
    localparam int BAND_W     = P_W + RINGS_W + 2;
    localparam int QH_W       = TRI_W - 2;
    localparam int QUOT_W     = RINGS_W;
    localparam int SEC_W      = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RINGS       = 2'd1;

    localparam logic [HALF_W-1:0]  HALF_POINTS_RST = 8'd8;
    localparam logic [RINGS_W-1:0] RINGS_RST       = 9'd7;

    localparam int DEFAULT_MAX_HALF_POINTS = 128;
    localparam int DEFAULT_MAX_RINGS       = 256;

    // restoring divider: QUOT_W steps spread over DIV_STAGES stages
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic [SEC_W-1:0] SEC_BOTTOM = 2'd0;
    localparam logic [SEC_W-1:0] SEC_BAND   = 2'd1;
    localparam logic [SEC_W-1:0] SEC_TOP    = 2'd2;

    // mesh geometry derived from the config registers
    typedef struct packed {
        logic [HALF_W-1:0] h;
        logic [P_W-1:0]    p;
        logic [BAND_W-1:0] band;
        logic [VERT_W-1:0] m;
        logic [VERT_W-1:0] rp1;
    } rmti_geom_t;

    // item in flight between classify and assemble
    typedef struct packed {
        logic [SEC_W-1:0]  section;
        logic              ok;
        logic              odd;
        logic              qb;
        logic [P_W-1:0]    u;
        logic [QH_W-1:0]   rem;
        logic [QUOT_W-1:0] quot;
    } rmti_mid_t;

    typedef struct packed {
        logic [VERT_W-1:0] vert_a;
        logic [VERT_W-1:0] vert_b;
        logic [VERT_W-1:0] vert_c;
        logic [SEC_W-1:0]  section;
        logic              in_range;
    } rmti_out_t;

endpackage

`default_nettype wire

[rtl/rmti_cfg_if.sv]
// ----------------------------------------------------------------------------
// Config write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmti_cfg_if;
    import rmti_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rmti_tri_in_if.sv]
// ----------------------------------------------------------------------------
// Triangle request channel
// One triangle number per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmti_tri_in_if;
    import rmti_pkg::*;

    logic             valid;
    logic             ready;
    logic [TRI_W-1:0] tri_number;

    modport source (output valid, tri_number, input ready);
    modport sink   (input valid, tri_number, output ready);
endinterface

`default_nettype wire

[rtl/rmti_tri_out_if.sv]
// ----------------------------------------------------------------------------
// Triangle result channel
// Three vertex indices, section and range flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmti_tri_out_if;
    import rmti_pkg::*;

    logic              valid;
    logic              ready;
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;
    logic [SEC_W-1:0]  section;
    logic              in_range;

    modport source (output valid, vert_a, vert_b, vert_c, section, in_range, input ready);
    modport sink   (input valid, vert_a, vert_b, vert_c, section, in_range, output ready);
endinterface

`default_nettype wire

[rtl/rmti_front.sv]
// ----------------------------------------------------------------------------
// Input register and section classifier
// Two stages: capture triangle number, then split into fan/band/out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module rmti_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rmti_pkg::rmti_geom_t       geom,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [rmti_pkg::TRI_W-1:0] in_tri,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output rmti_pkg::rmti_mid_t             out_data
);
    import rmti_pkg::*;

    logic             a_valid_reg;
    logic [TRI_W-1:0] a_tri_reg;
    logic             a_ready;
    logic             b_valid_reg;
    rmti_mid_t        b_data_reg;
    rmti_mid_t        b_data_next;
    logic             b_ready;

    logic [TRI_W-1:0] d;
    logic [TRI_W-1:0] f;
    logic             lt_p;
    logic             in_band;
    logic             in_top;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        lt_p    = a_tri_reg < TRI_W'(geom.p);
        d       = a_tri_reg - TRI_W'(geom.p);
        in_band = BAND_W'(d) < geom.band;
        // band fits in TRI_W whenever this is used
        f       = d - TRI_W'(geom.band);
        in_top  = f < TRI_W'(geom.p);

        b_data_next = '0;
        if (lt_p)
        begin
            b_data_next.section = SEC_BOTTOM;
            b_data_next.ok      = 1'b1;
            b_data_next.u       = a_tri_reg[P_W-1:0];
        end
        else if (in_band)
        begin
            // quad q = d/2, ring pos divides as (q/2)/h with q[0] kept aside
            b_data_next.section = SEC_BAND;
            b_data_next.ok      = 1'b1;
            b_data_next.odd     = d[0];
            b_data_next.qb      = d[1];
            b_data_next.rem     = d[TRI_W-1:2];
        end
        else if (in_top)
        begin
            b_data_next.section = SEC_TOP;
            b_data_next.ok      = 1'b1;
            b_data_next.u       = f[P_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_tri_reg <= in_tri;
        end
        if (a_valid_reg && b_ready)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

[rtl/rmti_div_stage.sv]
// ----------------------------------------------------------------------------
// Restoring divider stage
// Several quotient bits per stage, MSB first, of rem / h.
// ----------------------------------------------------------------------------
`default_nettype none

module rmti_div_stage #(
    parameter int FIRST_BIT = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rmti_pkg::rmti_geom_t geom,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rmti_pkg::rmti_mid_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rmti_pkg::rmti_mid_t       out_data
);
    import rmti_pkg::*;

    localparam int TRIAL_W = QH_W + 1;

    logic      valid_reg;
    rmti_mid_t data_reg;
    rmti_mid_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [TRIAL_W-1:0] trial;
        trial     = '0;
        data_next = in_data;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial = TRIAL_W'(geom.h) << (FIRST_BIT - s);
            if (TRIAL_W'(data_next.rem) >= trial)
            begin
                data_next.rem  = data_next.rem - trial[QH_W-1:0];
                data_next.quot = {data_next.quot[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                data_next.quot = {data_next.quot[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/rmti_assemble.sv]
// ----------------------------------------------------------------------------
// Vertex assembly and output register
// Ring base multiply, wrap of ring position, per-section vertex select.
// ----------------------------------------------------------------------------
`default_nettype none

module rmti_assemble (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rmti_pkg::rmti_geom_t geom,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rmti_pkg::rmti_mid_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rmti_pkg::rmti_out_t       out_data
);
    import rmti_pkg::*;

    logic      valid_reg;
    rmti_out_t data_reg;
    rmti_out_t data_next;

    logic [2*P_W-1:0]  lo_full;
    logic [VERT_W-1:0] lo;
    logic [VERT_W-1:0] hi;
    logic [P_W-1:0]    j;
    logic [P_W-1:0]    j1;
    logic [P_W-1:0]    n;
    logic [P_W-1:0]    u1;
    logic [P_W-1:0]    uw;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // ring position j = 2*(q/2 mod h) + q[0]; neighbor wraps at p
        j       = {in_data.rem[HALF_W-1:0], in_data.qb};
        j1      = j + 1'b1;
        n       = (j1 == geom.p) ? '0 : j1;
        lo_full = (2*P_W)'(in_data.quot) * (2*P_W)'(geom.p);
        lo      = lo_full[VERT_W-1:0];
        hi      = lo + VERT_W'(geom.p);
        u1      = in_data.u + 1'b1;
        uw      = (u1 == geom.p) ? '0 : u1;

        data_next          = '0;
        data_next.section  = in_data.section;
        data_next.in_range = in_data.ok;
        if (in_data.ok)
        begin
            case (in_data.section)
                SEC_BOTTOM:
                begin
                    data_next.vert_a = '0;
                    data_next.vert_b = VERT_W'(uw) + 1'b1;
                    data_next.vert_c = VERT_W'(u1);
                end
                SEC_BAND:
                begin
                    if (!in_data.odd)
                    begin
                        data_next.vert_a = lo + VERT_W'(j1);
                        data_next.vert_b = lo + VERT_W'(n) + 1'b1;
                    end
                    else
                    begin
                        data_next.vert_a = lo + VERT_W'(n) + 1'b1;
                        data_next.vert_b = hi + VERT_W'(n) + 1'b1;
                    end
                    data_next.vert_c = hi + VERT_W'(j1);
                end
                SEC_TOP:
                begin
                    data_next.vert_a = geom.rp1;
                    data_next.vert_b = geom.m + VERT_W'(u1);
                    data_next.vert_c = geom.m + VERT_W'(uw) + 1'b1;
                end
                default:
                begin
                    data_next.vert_a = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/ring_mesh_triangle_indexer.sv]
// ----------------------------------------------------------------------------
// Ring mesh triangle indexer
// Triangle number in, three vertex indices of a capped ring mesh out.
// ----------------------------------------------------------------------------
// Fully pipelined, one item per cycle sustained while tri_out is ready, six
// register stages (input register, classifier, three divider stages,
// assembly/output register), passed in that order by each triangle number
// on its way to tri_out. The depth is set by the band triangles: the ring
// and ring position come from dividing the quad number by the ring width,
// a 9-step restoring division run three quotient bits per stage. The mesh
// geometry (ring width, band size, top ring base) is re-registered every
// cycle from the config registers, so a config write applies to items
// accepted from the next cycle on. Config writes are always ready and are
// meant to be issued while no item is in flight. Any stall at tri_out backs
// up stage by stage; bubbles between stages are squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ring_mesh_triangle_indexer_macros.svh"

module ring_mesh_triangle_indexer #(
    parameter int unsigned MAX_HALF_POINTS = rmti_pkg::DEFAULT_MAX_HALF_POINTS,
    parameter int unsigned MAX_RINGS       = rmti_pkg::DEFAULT_MAX_RINGS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rmti_cfg_if.sink       cfg,
    rmti_tri_in_if.sink    tri_in,
    rmti_tri_out_if.source tri_out
);
    import rmti_pkg::*;

    // config registers hold the bits as written; limits apply on use
    logic [HALF_W-1:0]  half_points_reg;
    logic [RINGS_W-1:0] rings_reg;

    logic [HALF_W-1:0]    eff_h;
    logic [RINGS_W-1:0]   eff_r;
    logic [RINGS_W-1:0]   r_m1;
    logic [2*P_W-1:0]     m_full;
    rmti_geom_t           geom_next;
    rmti_geom_t           geom_reg;

    // pipeline links
    logic      fr_valid;
    logic      fr_ready;
    rmti_mid_t fr_data;
    logic      dv_valid [DIV_STAGES+1];
    logic      dv_ready [DIV_STAGES+1];
    rmti_mid_t dv_data  [DIV_STAGES+1];
    rmti_out_t res;

    // ---------------- config port ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_points_reg <= HALF_POINTS_RST;
            rings_reg       <= RINGS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HALF_POINTS: half_points_reg <= cfg.data[HALF_W-1:0];
                CFG_RINGS:       rings_reg       <= cfg.data[RINGS_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- geometry ----------------
    // Clamp to the legal ranges, then precompute per-config values:
    //   p    = 2h        ring width
    //   band = 2p(r-1)   band triangle count
    //   m    = (r-1)p    base of the top ring (mod 2^17)
    //   rp1  = rp+1      top pole vertex (mod 2^17)
    always_comb
    begin
        if (half_points_reg < HALF_W'(2))
        begin
            eff_h = HALF_W'(2);
        end
        else if (32'(half_points_reg) > MAX_HALF_POINTS)
        begin
            eff_h = HALF_W'(MAX_HALF_POINTS);
        end
        else
        begin
            eff_h = half_points_reg;
        end

        if (rings_reg == '0)
        begin
            eff_r = RINGS_W'(1);
        end
        else if (32'(rings_reg) > MAX_RINGS)
        begin
            eff_r = RINGS_W'(MAX_RINGS);
        end
        else
        begin
            eff_r = rings_reg;
        end

        r_m1           = eff_r - 1'b1;
        geom_next.h    = eff_h;
        geom_next.p    = {eff_h, 1'b0};
        m_full         = (2*P_W)'(r_m1) * (2*P_W)'(geom_next.p);
        geom_next.band = BAND_W'({m_full, 1'b0});
        geom_next.m    = m_full[VERT_W-1:0];
        geom_next.rp1  = m_full[VERT_W-1:0] + VERT_W'(geom_next.p) + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    // ---------------- pipeline ----------------
    rmti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .in_valid  (tri_in.valid),
        .in_ready  (tri_in.ready),
        .in_tri    (tri_in.tri_number),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    assign dv_valid[0] = fr_valid;
    assign dv_data[0]  = fr_data;
    assign fr_ready    = dv_ready[0];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        rmti_div_stage #(
            .FIRST_BIT (QUOT_W - 1 - g * DIV_STEPS)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .geom      (geom_reg),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    rmti_assemble u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom_reg),
        .in_valid  (dv_valid[DIV_STAGES]),
        .in_ready  (dv_ready[DIV_STAGES]),
        .in_data   (dv_data[DIV_STAGES]),
        .out_valid (tri_out.valid),
        .out_ready (tri_out.ready),
        .out_data  (res)
    );

    assign tri_out.vert_a   = res.vert_a;
    assign tri_out.vert_b   = res.vert_b;
    assign tri_out.vert_c   = res.vert_c;
    assign tri_out.section  = res.section;
    assign tri_out.in_range = res.in_range;

    // ---------------- checks ----------------
    `RMTI_ASSERT_IMP(a_oor_zero, clk, rst_n,
        tri_out.valid && !tri_out.in_range,
        tri_out.vert_a == '0 && tri_out.vert_b == '0 && tri_out.vert_c == '0 &&
        tri_out.section == SEC_BOTTOM,
        "out of range result not cleared")
    `RMTI_ASSERT_IMP(a_bottom_pole, clk, rst_n,
        tri_out.valid && tri_out.in_range && tri_out.section == SEC_BOTTOM,
        tri_out.vert_a == '0,
        "bottom fan triangle without pole vertex")
    `RMTI_ASSERT_IMP(a_backpressure_src, clk, rst_n,
        !tri_in.ready,
        tri_out.valid && !tri_out.ready,
        "input stalled while output is not stalled")
    `RMTI_ASSERT_NXT(a_cfg_half_write, clk, rst_n,
        cfg.valid && cfg.ready && cfg.index == CFG_HALF_POINTS,
        half_points_reg == $past(cfg.data[HALF_W-1:0]),
        "half_points write lost")

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Ring mesh triangle indexer testbench
// Drives triangle numbers over several mesh settings, predicts the three
// vertex indices, section and range flag of each, and checks every result
// in order while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmti_pkg::*;

    // register indexes the block does not decode; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int unsigned TRI_MAX     = (1 << TRI_W) - 1;
    localparam int unsigned IDLE_PCT    = 13;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_WAIT  = 20;     // well past the trip through the pipeline
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rmti_cfg_if     cfg_ch ();
    rmti_tri_in_if  tri_req ();
    rmti_tri_out_if tri_res ();

    ring_mesh_triangle_indexer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .tri_in  (tri_req),
        .tri_out (tri_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the mesh registers, raw bits as written.
    logic [HALF_W-1:0]  half_points_cfg = HALF_POINTS_RST;
    logic [RINGS_W-1:0] rings_cfg       = RINGS_RST;

    rmti_out_t   pending_triangles[$];
    int unsigned failures = 0;
    int unsigned cycles   = 0;

    // Idle control shared by sender and receiver. A hold starts whenever
    // hold_req toggles; hold_ack follows it on the receiver side.
    logic no_idle  = 1'b0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int unsigned hold_left = 0;

    // ------------------------------------------------------------------------
    // Mesh geometry as the block sees it: register values saturate on use.
    // ------------------------------------------------------------------------
    function automatic int unsigned ring_width();
        int unsigned h;
        h = half_points_cfg;
        if (h < 2) h = 2;
        if (h > DEFAULT_MAX_HALF_POINTS) h = DEFAULT_MAX_HALF_POINTS;
        return 2 * h;
    endfunction

    function automatic int unsigned ring_count();
        int unsigned r;
        r = rings_cfg;
        if (r < 1) r = 1;
        if (r > DEFAULT_MAX_RINGS) r = DEFAULT_MAX_RINGS;
        return r;
    endfunction

    // Vertex indices of one triangle: bottom fan, band quads, top fan.
    function automatic rmti_out_t triangle_vertices(input logic [TRI_W-1:0] tri_num);
        int unsigned p, r, t, band, quad, ring, pos, nxt, lo, hi, f, m;
        rmti_out_t v;
        p    = ring_width();
        r    = ring_count();
        t    = tri_num;
        band = 2 * p * (r - 1);
        v    = '0;
        if (t < p) begin
            v.vert_b   = VERT_W'((t + 1) % p + 1);
            v.vert_c   = VERT_W'(t + 1);
            v.section  = SEC_BOTTOM;
            v.in_range = 1'b1;
        end
        else if (t - p < band) begin
            quad = (t - p) >> 1;
            ring = quad / p;
            pos  = quad % p;
            nxt  = (pos + 1) % p;
            lo   = ring * p;
            hi   = lo + p;
            if (((t - p) & 1) == 0) begin
                v.vert_a = VERT_W'(lo + pos + 1);
                v.vert_b = VERT_W'(lo + nxt + 1);
                v.vert_c = VERT_W'(hi + pos + 1);
            end
            else begin
                v.vert_a = VERT_W'(lo + nxt + 1);
                v.vert_b = VERT_W'(hi + nxt + 1);
                v.vert_c = VERT_W'(hi + pos + 1);
            end
            v.section  = SEC_BAND;
            v.in_range = 1'b1;
        end
        else if (t - p - band < p) begin
            f = t - p - band;
            m = (r - 1) * p;
            v.vert_a   = VERT_W'(r * p + 1);
            v.vert_b   = VERT_W'(m + f + 1);
            v.vert_c   = VERT_W'(m + (f + 1) % p + 1);
            v.section  = SEC_TOP;
            v.in_range = 1'b1;
        end
        // past the total: all zero, in_range low
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready pattern and in-order checking.
    // ------------------------------------------------------------------------
    // Random stalls, none while no_idle is set; a hold request forces a long
    // stretch of ready low so the pipeline fills and backs up to tri_in.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            tri_res.ready <= 1'b0;
        end
        else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     = HOLD_CYCLES - 1;
            tri_res.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            tri_res.ready <= 1'b0;
        end
        else if (no_idle) begin
            tri_res.ready <= 1'b1;
        end
        else begin
            tri_res.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        rmti_out_t want;
        if (rst_n && tri_res.valid && tri_res.ready) begin
            if (pending_triangles.size() == 0) begin
                $error("result item with nothing expected: a=%0d b=%0d c=%0d",
                       tri_res.vert_a, tri_res.vert_b, tri_res.vert_c);
                failures++;
            end
            else begin
                want = pending_triangles.pop_front();
                compare_field("vert_a",   want.vert_a,   tri_res.vert_a);
                compare_field("vert_b",   want.vert_b,   tri_res.vert_b);
                compare_field("vert_c",   want.vert_c,   tri_res.vert_c);
                compare_field("section",  want.section,  tri_res.section);
                compare_field("in_range", want.in_range, tri_res.in_range);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one triangle number; random idle cycles go in front of it.
    // The expectation is taken at the accepting edge with the current mesh.
    task automatic send_triangle(input int unsigned tn);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            tri_req.valid <= 1'b0;
            @(posedge clk);
        end
        tri_req.valid      <= 1'b1;
        tri_req.tri_number <= TRI_W'(tn);
        do @(posedge clk); while (!tri_req.ready);
        pending_triangles.insert(pending_triangles.size(), triangle_vertices(TRI_W'(tn)));
    endtask

    // Stop offering and let every outstanding item come back.
    task automatic drain();
        tri_req.valid <= 1'b0;
        while (pending_triangles.size() != 0) @(posedge clk);
    endtask

    // Register write, only with the pipeline empty. With more set, valid is
    // left high so a following write does not lower and raise it in one step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                                  input bit more = 1'b0);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        if (!more) cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_HALF_POINTS: half_points_cfg = data[HALF_W-1:0];
            CFG_RINGS:       rings_cfg       = data[RINGS_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic program_mesh(input int unsigned half, input int unsigned ring_num);
        write_register(CFG_HALF_POINTS, half, 1'b1);
        write_register(CFG_RINGS, ring_num);
    endtask

    // Mostly in-range numbers, some on section edges, some anywhere in 17 bits.
    function automatic int unsigned pick_triangle();
        int unsigned p, band, total, roll, t;
        p     = ring_width();
        band  = 2 * p * (ring_count() - 1);
        total = band + 2 * p;
        roll  = $urandom_range(99);
        if (roll < 12) return $urandom_range(TRI_MAX, 0);
        if (roll < 20) begin
            case ($urandom_range(5, 0))
                0:       t = p - 1;
                1:       t = p;
                2:       t = p + band - 1;
                3:       t = p + band;
                4:       t = total - 1;
                default: t = total;
            endcase
            return (t > TRI_MAX) ? TRI_MAX : t;
        end
        return $urandom_range(total - 1, 0);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset mesh: 16 per ring, 7 rings, 224 triangles. Section edges,
    // first number past the total and the all-ones number.
    task automatic test_default_mesh();
        send_triangle(0);
        send_triangle(15);
        send_triangle(16);
        send_triangle(17);
        send_triangle(207);
        send_triangle(208);
        send_triangle(223);
        send_triangle(224);
        send_triangle(TRI_MAX);
    endtask

    // Register saturation, masking of the write data, spare indexes and the
    // largest mesh, whose last top fan triangle is the all-ones number.
    task automatic test_register_limits();
        program_mesh(0, 0);                 // counts as 2 and 1: fans only
        send_triangle(0);
        send_triangle(3);
        send_triangle(4);
        send_triangle(7);
        send_triangle(8);

        program_mesh(9'h1FF, 9'h1FF);       // 0xFF over max, 511 over max
        send_triangle(0);
        send_triangle(255);
        send_triangle(256);
        send_triangle(257);
        send_triangle(130815);
        send_triangle(130816);
        send_triangle(TRI_MAX);

        write_register(CFG_SPARE_A, 9'h003, 1'b1);
        write_register(CFG_SPARE_B, 9'h002);
        send_triangle(65536);
        send_triangle(TRI_MAX);

        program_mesh(1, 2);                 // cylinder with the narrowest ring
        send_triangle(5);
        send_triangle(15);
        send_triangle(16);

        program_mesh(9'h102, 129);          // bit 8 dropped: 2; rings 129
        send_triangle(1000);
    endtask

    // Random numbers over a run of mesh settings, extremes first; one
    // phase runs with no idling on either side.
    task automatic test_random_meshes();
        int unsigned half, ring_num;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                half     = 2;
                ring_num = 1;
            end
            else if (phase == 1) begin
                half     = DEFAULT_MAX_HALF_POINTS;
                ring_num = DEFAULT_MAX_RINGS;
            end
            else begin
                half     = ($urandom_range(99) < 70) ? $urandom_range(12, 2)
                                                     : $urandom_range(511, 0);
                ring_num = ($urandom_range(99) < 70) ? $urandom_range(10, 1)
                                                     : $urandom_range(511, 0);
            end
            program_mesh(half, ring_num);
            no_idle <= (phase == 3);
            for (int k = 0; k < 130; k++) send_triangle(pick_triangle());
        end
        no_idle <= 1'b0;
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // pipeline fills and tri_in stalls.
    task automatic test_backpressure();
        program_mesh(5, 4);
        no_idle  <= 1'b1;
        hold_req <= !hold_req;
        for (int k = 0; k < 80; k++) send_triangle(pick_triangle());
        no_idle <= 1'b0;
    endtask

    initial
    begin
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_HALF_POINTS;
        cfg_ch.data        <= '0;
        tri_req.valid      <= 1'b0;
        tri_req.tri_number <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_default_mesh();
        test_register_limits();
        test_random_meshes();
        test_backpressure();

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/rmti_pkg.sv
rtl/rmti_cfg_if.sv
rtl/rmti_tri_in_if.sv
rtl/rmti_tri_out_if.sv
rtl/rmti_front.sv
rtl/rmti_div_stage.sv
rtl/rmti_assemble.sv
rtl/ring_mesh_triangle_indexer.sv
test/tb_top.sv
